// ===== hdl/pfair_pkg.sv =====
`default_nettype none

package pfair_pkg;

   // key square geometry
   localparam int SQ_DIM    = 5;
   localparam int LETTER_W  = 5;
   localparam int POS_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int ROW_W     = SQ_DIM * LETTER_W;

   typedef logic [LETTER_W-1:0]               letter_type;
   typedef logic [POS_W-1:0]                  pos_type;
   typedef logic [SQ_DIM-1:0][LETTER_W-1:0]   row_type;

   localparam pos_type LAST_POS = pos_type'(SQ_DIM - 1);

   // register map: indexes below SQ_DIM select a square row
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LIMIT = CSR_IDX_W'(SQ_DIM);
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = CSR_IDX_W'(SQ_DIM);

   typedef enum logic {
      DIR_ENCRYPT = 1'b0,
      DIR_DECRYPT = 1'b1
   } dir_type;

   // identity square, cell (r,c) holds 5r+c
   localparam row_type SQUARE_RESET [SQ_DIM] = '{
      row_type'(25'd4294688),
      row_type'(25'd9706693),
      row_type'(25'd15118698),
      row_type'(25'd20530703),
      row_type'(25'd25942708)
   };

endpackage

`default_nettype wire

// ===== hdl/playfair_digraph_substitution.sv =====
`default_nettype none
// A request taken on start passes through two register stages before its result shows on rsp_*
//   (request register, result register).
// Throughput: one digraph per clock; busy is never raised and the receiver cannot stall.
// Reset (synchronous, active high): pipeline emptied, square back to identity, encrypt mode.
// Configuration writes are taken every cycle (csr_ready tied high) and act on later lookups.

module playfair_digraph_substitution
   import pfair_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [LETTER_W-1:0]    req_first_letter,
   input  wire logic [LETTER_W-1:0]    req_second_letter,
   // result channel, one-cycle strobe
   output logic                        rsp_valid,
   output logic [LETTER_W-1:0]         rsp_out_first,
   output logic [LETTER_W-1:0]         rsp_out_second,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ROW_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   row_type    square_ff [SQ_DIM];
   dir_type    direction_ff;
   logic       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < SQ_DIM; r++) begin
            square_ff[r] <= SQUARE_RESET[r];
         end
         direction_ff <= DIR_ENCRYPT;
      end else if (csr_write) begin
         if (csr_index < CSR_ROW_LIMIT) begin
            square_ff[csr_index] <= row_type'(csr_wdata);
         end else if (csr_index == CSR_DIRECTION) begin
            direction_ff <= dir_type'(csr_wdata[0]);
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 1: request register
   // ---------------------------------------------------------------
   logic       req_take;
   logic       s1_valid_ff;
   letter_type s1_first_ff;
   letter_type s1_second_ff;

   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take;
      end
      if (req_take) begin
         s1_first_ff  <= req_first_letter;
         s1_second_ff <= req_second_letter;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: locate both letters, pick the substitute cells
   // ---------------------------------------------------------------
   pos_type    f_row, f_col, s_row, s_col;
   pos_type    fa_row, fa_col, sb_row, sb_col;
   logic       back;
   letter_type rsp_first_in;
   letter_type rsp_second_in;

   // step one position with wrap at the square edge
   function automatic pos_type step_pos(input pos_type pos, input logic go_back);
      pos_type res;
      if (go_back) begin
         res = (pos == '0) ? LAST_POS : pos - pos_type'(1);
      end else begin
         res = (pos == LAST_POS) ? '0 : pos + pos_type'(1);
      end
      return res;
   endfunction

   assign back = (direction_ff == DIR_DECRYPT);

   // scan in reverse so the first match in row-major order wins; no match lands on (0,0)
   always_comb begin
      f_row = '0;
      f_col = '0;
      s_row = '0;
      s_col = '0;
      for (int r = SQ_DIM - 1; r >= 0; r--) begin
         for (int c = SQ_DIM - 1; c >= 0; c--) begin
            if (square_ff[r][c] == s1_first_ff) begin
               f_row = pos_type'(r);
               f_col = pos_type'(c);
            end
            if (square_ff[r][c] == s1_second_ff) begin
               s_row = pos_type'(r);
               s_col = pos_type'(c);
            end
         end
      end
   end

   always_comb begin
      if (f_row != s_row && f_col != s_col) begin
         // rectangle: swap columns
         fa_row = f_row;
         fa_col = s_col;
         sb_row = s_row;
         sb_col = f_col;
      end else if (f_col == s_col) begin
         // same column (also identical letters): move down / up
         fa_row = step_pos(f_row, back);
         fa_col = f_col;
         sb_row = step_pos(s_row, back);
         sb_col = s_col;
      end else begin
         // same row: move right / left
         fa_row = f_row;
         fa_col = step_pos(f_col, back);
         sb_row = s_row;
         sb_col = step_pos(s_col, back);
      end
      rsp_first_in  = square_ff[fa_row][fa_col];
      rsp_second_in = square_ff[sb_row][sb_col];
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic       rsp_valid_ff;
   letter_type rsp_first_ff;
   letter_type rsp_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ##1 rsp_valid)
      else $error("request did not produce a result two cycles later");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> ##1 !rsp_valid)
      else $error("result strobe without a request");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> (rsp_valid && rsp_out_first == $past(rsp_first_in)))
      else $error("result register lost stage data");

   a_double_letter: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_first_ff == s1_second_ff) |=> rsp_out_first == rsp_out_second)
      else $error("identical letters gave different substitutes");

endmodule

`default_nettype wire
